@@ src/fjp_pkg.sv @@
// package: item types, job record, parser codes and character classes
package fjp_pkg;

  localparam int PID_CHARS     = 15;
  localparam int VERSION_CHARS = 15;
  localparam int MAX_TEXT      = 1024;

  localparam int LEN_W      = $clog2(MAX_TEXT);
  localparam int PCNT_W     = $clog2(PID_CHARS + 1);
  localparam int VCNT_W     = $clog2(VERSION_CHARS + 1);
  localparam int PID_IDX_W  = (PID_CHARS > 1) ? $clog2(PID_CHARS) : 1;
  localparam int VER_IDX_W  = (VERSION_CHARS > 1) ? $clog2(VERSION_CHARS) : 1;
  localparam int MAX_CHARS  = (PID_CHARS > VERSION_CHARS) ? PID_CHARS : VERSION_CHARS;
  localparam int CNT_W      = $clog2(MAX_CHARS + 1);
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = 1;
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  // character codes
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_P      = 8'h70;
  localparam logic [7:0] CH_V      = 8'h76;

  // result kinds
  localparam logic [1:0] KIND_STATUS  = 2'd0;
  localparam logic [1:0] KIND_PID     = 2'd1;
  localparam logic [1:0] KIND_VERSION = 2'd2;

  typedef enum logic [3:0] {
    PH_START       = 4'd0,
    PH_OPENED      = 4'd1,
    PH_KEY         = 4'd2,
    PH_AFTER_KEY   = 4'd3,
    PH_BEFORE_VAL  = 4'd4,
    PH_VAL         = 4'd5,
    PH_AFTER_VAL   = 4'd6,
    PH_AFTER_COMMA = 4'd7,
    PH_DONE        = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    KEY_NONE = 2'd0,
    KEY_P    = 2'd1,
    KEY_V    = 2'd2
  } key_t;

  typedef enum logic [1:0] {
    BK_STATUS  = 2'd0,
    BK_PID     = 2'd1,
    BK_VERSION = 2'd2
  } back_state_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
    logic       fw_update_present;
    logic       fw_update_capable;
  } byte_item_t;

  typedef struct packed {
    logic [1:0] item_kind;
    logic [7:0] char_out;
    logic       message_valid;
    logic [9:0] pid_full_length;
    logic       version_present;
    logic       echo_ota_present;
    logic       echo_ota_capable;
    logic       run_end;
  } result_t;

  // one finished message, handed from parser to emitter
  typedef struct packed {
    logic                              message_valid;
    logic [LEN_W-1:0]                  pid_full_length;
    logic                              version_present;
    logic                              echo_ota_present;
    logic                              echo_ota_capable;
    logic [PCNT_W-1:0]                 pid_count;
    logic [VCNT_W-1:0]                 version_count;
    logic [PID_CHARS-1:0][7:0]         pid_chars;
    logic [VERSION_CHARS-1:0][7:0]     version_chars;
  } job_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_bad_str(input logic [7:0] c);
    return (c < CH_SPACE) || (c == CH_BSLASH);
  endfunction

endpackage

@@ src/fjp_front.sv @@
// front end: byte-wise json parser and capture of pid and version text
module fjp_front
  import fjp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  byte_item_t byte_item,
  output logic       job_push,
  output job_t       job
);

  phase_t           phase, phase_next;
  key_t             key_match, key_match_next;
  logic             pid_seen, pid_seen_next;
  logic             version_seen, version_seen_next;
  logic             error_latched, error_latched_next;
  logic [LEN_W-1:0] value_length, value_length_next;
  logic [LEN_W-1:0] pid_length_count, pid_length_count_next;
  logic [VCNT_W-1:0] version_length_count, version_length_count_next;

  logic [PID_CHARS-1:0][7:0]     pid_chars;
  logic [VERSION_CHARS-1:0][7:0] version_chars;

  logic [7:0]       c;
  logic             err;
  logic [LEN_W-1:0] len_bumped;
  logic             wr_pid, wr_ver;
  logic             valid;

  assign c = byte_item.text_byte;
  assign len_bumped = (value_length < LEN_W'(MAX_TEXT - 1)) ?
                      value_length + LEN_W'(1) : value_length;

  // one parse step on the current byte
  always_comb begin
    phase_next                = phase;
    key_match_next            = key_match;
    pid_seen_next             = pid_seen;
    version_seen_next         = version_seen;
    value_length_next         = value_length;
    pid_length_count_next     = pid_length_count;
    version_length_count_next = version_length_count;
    err    = 1'b0;
    wr_pid = 1'b0;
    wr_ver = 1'b0;
    case (phase)
      PH_START: begin
        if (c == CH_LBRACE) phase_next = PH_OPENED;
        else if (!is_ws(c)) err = 1'b1;
      end
      PH_OPENED, PH_AFTER_COMMA: begin
        if (c == CH_RBRACE && phase == PH_OPENED) begin
          phase_next = PH_DONE;
        end else if (c == CH_QUOTE) begin
          phase_next        = PH_KEY;
          key_match_next    = KEY_NONE;
          value_length_next = '0;
        end else if (!is_ws(c)) begin
          err = 1'b1;
        end
      end
      PH_KEY: begin
        if (c == CH_QUOTE) begin
          if ((key_match == KEY_P && pid_seen) || (key_match == KEY_V && version_seen))
            err = 1'b1;
          else
            phase_next = PH_AFTER_KEY;
        end else if (is_bad_str(c)) begin
          err = 1'b1;
        end else begin
          if (value_length == '0)
            key_match_next = (c == CH_P) ? KEY_P : (c == CH_V) ? KEY_V : KEY_NONE;
          else
            key_match_next = KEY_NONE;
          value_length_next = len_bumped;
        end
      end
      PH_AFTER_KEY: begin
        if (c == CH_COLON) phase_next = PH_BEFORE_VAL;
        else if (!is_ws(c)) err = 1'b1;
      end
      PH_BEFORE_VAL: begin
        if (c == CH_QUOTE) begin
          phase_next        = PH_VAL;
          value_length_next = '0;
        end else if (!is_ws(c)) begin
          err = 1'b1;
        end
      end
      PH_VAL: begin
        if (c == CH_QUOTE) begin
          if (key_match == KEY_P && value_length == '0) begin
            err = 1'b1;
          end else begin
            if (key_match == KEY_P) begin
              pid_seen_next         = 1'b1;
              pid_length_count_next = value_length;
            end else if (key_match == KEY_V) begin
              version_seen_next = 1'b1;
              version_length_count_next =
                (value_length < LEN_W'(VERSION_CHARS)) ?
                VCNT_W'(value_length) : VCNT_W'(VERSION_CHARS);
            end
            phase_next = PH_AFTER_VAL;
          end
        end else if (is_bad_str(c)) begin
          err = 1'b1;
        end else begin
          wr_pid = (key_match == KEY_P) && (value_length < LEN_W'(PID_CHARS));
          wr_ver = (key_match == KEY_V) && (value_length < LEN_W'(VERSION_CHARS));
          value_length_next = len_bumped;
        end
      end
      PH_AFTER_VAL: begin
        if (c == CH_RBRACE) phase_next = PH_DONE;
        else if (c == CH_COMMA) phase_next = PH_AFTER_COMMA;
        else if (!is_ws(c)) err = 1'b1;
      end
      PH_DONE: begin
        if (!is_ws(c)) err = 1'b1;
      end
      default: err = 1'b1;
    endcase
    // a latched error freezes the parse
    if (error_latched) begin
      phase_next                = phase;
      key_match_next            = key_match;
      pid_seen_next             = pid_seen;
      version_seen_next         = version_seen;
      value_length_next         = value_length;
      pid_length_count_next     = pid_length_count;
      version_length_count_next = version_length_count;
      err    = 1'b0;
      wr_pid = 1'b0;
      wr_ver = 1'b0;
    end
    error_latched_next = error_latched | err;
  end

  // job record built on the final byte
  assign valid    = !error_latched_next && (phase_next == PH_DONE) && pid_seen_next;
  assign job_push = accept && byte_item.final_byte;

  always_comb begin
    job.message_valid    = valid;
    job.pid_full_length  = valid ? pid_length_count_next : '0;
    job.version_present  = valid && version_seen_next;
    job.echo_ota_present = byte_item.fw_update_present;
    job.echo_ota_capable = byte_item.fw_update_capable;
    job.pid_count        = '0;
    job.version_count    = '0;
    if (valid) begin
      job.pid_count = (pid_length_count_next < LEN_W'(PID_CHARS)) ?
                      PCNT_W'(pid_length_count_next) : PCNT_W'(PID_CHARS);
      job.version_count = version_seen_next ? version_length_count_next : '0;
    end
    job.pid_chars     = pid_chars;
    job.version_chars = version_chars;
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst || (accept && byte_item.final_byte)) begin
      phase                <= PH_START;
      key_match            <= KEY_NONE;
      pid_seen             <= 1'b0;
      version_seen         <= 1'b0;
      error_latched        <= 1'b0;
      value_length         <= '0;
      pid_length_count     <= '0;
      version_length_count <= '0;
    end else if (accept) begin
      phase                <= phase_next;
      key_match            <= key_match_next;
      pid_seen             <= pid_seen_next;
      version_seen         <= version_seen_next;
      error_latched        <= error_latched_next;
      value_length         <= value_length_next;
      pid_length_count     <= pid_length_count_next;
      version_length_count <= version_length_count_next;
    end
  end

  // captured text stores
  always_ff @(posedge clk) begin
    if (accept && wr_pid) pid_chars[value_length[PID_IDX_W-1:0]] <= c;
    if (accept && wr_ver) version_chars[value_length[VER_IDX_W-1:0]] <= c;
  end

endmodule

@@ src/fjp_queue.sv @@
// two-entry job queue between parser and emitter
module fjp_queue
  import fjp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic full,
  output logic empty
);

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QDEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop && !empty) rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push && !full) slots[wr_ptr] <= push_job;
  end

endmodule

@@ src/fjp_back.sv @@
// back end: walks one job and presents its run of result items
module fjp_back
  import fjp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  job_t    job,
  input  logic    job_ready,
  input  logic    pop,
  output result_t result,
  output logic    job_done
);

  back_state_t      state, state_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic             last;
  logic             take;
  logic [CNT_W-1:0] idx_inc;
  logic [CNT_W-1:0] pn, vn;

  assign take    = pop && job_ready;
  assign idx_inc = idx + CNT_W'(1);
  assign pn      = CNT_W'(job.pid_count);
  assign vn      = CNT_W'(job.version_count);

  // next state and last-item detection
  always_comb begin
    state_next = state;
    idx_next   = idx;
    last       = 1'b0;
    case (state)
      BK_STATUS: begin
        if (pn != '0) begin
          state_next = BK_PID;
          idx_next   = '0;
        end else if (vn != '0) begin
          state_next = BK_VERSION;
          idx_next   = '0;
        end else begin
          last = 1'b1;
        end
      end
      BK_PID: begin
        if (idx_inc < pn) begin
          idx_next = idx_inc;
        end else if (vn != '0) begin
          state_next = BK_VERSION;
          idx_next   = '0;
        end else begin
          last = 1'b1;
        end
      end
      BK_VERSION: begin
        if (idx_inc < vn) idx_next = idx_inc;
        else last = 1'b1;
      end
      default: last = 1'b1;
    endcase
    if (last) begin
      state_next = BK_STATUS;
      idx_next   = '0;
    end
  end

  assign job_done = take && last;

  // result fields for the current position
  always_comb begin
    result = '0;
    result.run_end = last;
    case (state)
      BK_STATUS: begin
        result.item_kind        = KIND_STATUS;
        result.message_valid    = job.message_valid;
        result.pid_full_length  = 10'(job.pid_full_length);
        result.version_present  = job.version_present;
        result.echo_ota_present = job.echo_ota_present;
        result.echo_ota_capable = job.echo_ota_capable;
      end
      BK_PID: begin
        result.item_kind = KIND_PID;
        result.char_out  = job.pid_chars[idx[PID_IDX_W-1:0]];
      end
      BK_VERSION: begin
        result.item_kind = KIND_VERSION;
        result.char_out  = job.version_chars[idx[VER_IDX_W-1:0]];
      end
      default: result.item_kind = KIND_STATUS;
    endcase
  end

  // position registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_STATUS;
      idx   <= '0;
    end else if (take) begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

endmodule

@@ src/flat_json_pid_version_extractor.sv @@
// top level: flat json pid and version extractor
//
// Input channel: one message byte per item with push/full; an item is taken
// at a clock edge with push high and full low. final_byte marks the last byte
// of a message; the two ota flags of that byte are echoed in its status.
// The parser takes one byte per cycle while full is low, back to back, with
// no gaps between messages. full rises only while the two-entry job queue
// holds two finished messages that have not yet been fully read out.
// Result channel: a queue read port. While empty is low the oldest result is
// on result; pop with empty low takes it. Each message gives a status item,
// then for a valid message its pid characters and version characters;
// run_end marks the last item of each run. One result can be taken per cycle.
// Latency: the status of a message is visible the cycle after its final
// byte is taken, when no earlier run is still being read out.
// A stalled reader holds results in place; parsing continues until the job
// queue fills, then full holds off further bytes.
// Reset (rst, synchronous) empties the queue and returns the parser to the
// start of a message; no clearing pass is needed.
module flat_json_pid_version_extractor
  import fjp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  byte_item_t byte_item,
  output logic       empty,
  input  logic       pop,
  output result_t    result
);

  logic accept;
  logic job_push;
  job_t front_job;
  job_t head_job;
  logic job_done;

  assign accept = push && !full;

  // parser
  fjp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .byte_item (byte_item),
    .job_push  (job_push),
    .job       (front_job)
  );

  // finished-message queue
  fjp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (front_job),
    .pop      (job_done),
    .head     (head_job),
    .full     (full),
    .empty    (empty)
  );

  // result emitter
  fjp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (head_job),
    .job_ready (!empty),
    .pop       (pop),
    .result    (result),
    .job_done  (job_done)
  );

endmodule
